// File: rtl/tmt_pkg.sv
// Shared types and constants of the text-mode terminal.
package tmt_pkg;

    localparam int CELL_W       = 16;
    localparam int IN_TDATA_W   = 24;
    localparam int OUT_TDATA_W  = 40;
    localparam int PADDR_W      = 3;

    localparam int OP_W         = 2;
    localparam int CHAR_W       = 8;
    localparam int RROW_W       = 5;
    localparam int RCOL_W       = 7;
    localparam int OROW_W       = 5;
    localparam int OCOL_W       = 7;
    localparam int OLIN_W       = 11;

    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

    localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;

    localparam logic [PADDR_W-1:0] ADDR_FG = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_BG = 3'd4;

    localparam logic [3:0] FG_RESET = 4'd7;
    localparam logic [3:0] BG_RESET = 4'd0;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_RWAIT,
        ST_COPY,
        ST_FILL,
        ST_DONE
    } state_t;

endpackage

// File: rtl/tmt_apb_regs.sv
// APB configuration registers: foreground and background color.
module tmt_apb_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tmt_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output logic [7:0]                   attr
);

    logic [3:0] fg_reg;
    logic [3:0] bg_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= tmt_pkg::FG_RESET;
            bg_reg <= tmt_pkg::BG_RESET;
        end
        else if (wr_en)
        begin
            if (paddr == tmt_pkg::ADDR_FG)
            begin
                fg_reg <= pwdata[3:0];
            end
            if (paddr == tmt_pkg::ADDR_BG)
            begin
                bg_reg <= pwdata[3:0];
            end
        end
    end

    always_comb
    begin
        case (paddr)
            tmt_pkg::ADDR_FG: prdata = {28'd0, fg_reg};
            tmt_pkg::ADDR_BG: prdata = {28'd0, bg_reg};
            default:          prdata = 32'd0;
        endcase
    end

    assign attr = {bg_reg, fg_reg};

endmodule

// File: rtl/tmt_screen_ram.sv
// Screen store: one write port, one registered read port.
module tmt_screen_ram
#(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
)
(
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [tmt_pkg::CELL_W-1:0]  wdata,
    input  logic                        re,
    input  logic [AW-1:0]               raddr,
    output logic [tmt_pkg::CELL_W-1:0]  rdata
);

    logic [tmt_pkg::CELL_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/text_mode_terminal_core.sv
// Top level: character-cell terminal sequencer with cursor and screen store.
// A put, return or backspace runs the execute and done states; a read adds the read-wait state.
// The done state loads the result register and takes the next command once the output is free.
// A scroll adds a copy pass, then a blank of the last row; a clear adds a blank fill of the screen.
// Reset: the sequencer walks all ROWS*COLS cells of the screen RAM (2000 by default),
// writing 0x0720, one cell a cycle, with s_tready low; configuration writes still apply.
module text_mode_terminal_core
#(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // operation[1:0], char_code[9:2], read_row[14:10], read_column[21:15]
    input  logic [tmt_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // cursor_row[4:0], cursor_column[11:5], cursor_linear[22:12],
    // cell_value[38:23], did_scroll[39]
    output logic [tmt_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tmt_pkg::PADDR_W-1:0]      paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    localparam int CELLS = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(SCREEN_COLUMNS);
    localparam int RW    = $clog2(SCREEN_ROWS);
    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [AW-1:0] COPY_N    = AW'(CELLS - SCREEN_COLUMNS);
    localparam logic [AW-1:0] COLS_A    = AW'(SCREEN_COLUMNS);
    localparam logic [CW-1:0] LAST_COL  = CW'(SCREEN_COLUMNS - 1);
    localparam logic [RW-1:0] LAST_ROW  = RW'(SCREEN_ROWS - 1);

    tmt_pkg::state_t state_reg, state_next;

    logic [AW-1:0]                  cnt_reg, cnt_next;
    logic [RW-1:0]                  row_reg, row_next;
    logic [CW-1:0]                  col_reg, col_next;
    logic [AW-1:0]                  base_reg, base_next;
    logic [tmt_pkg::OP_W-1:0]       op_reg, op_next;
    logic [tmt_pkg::CHAR_W-1:0]     ch_reg, ch_next;
    logic [tmt_pkg::RROW_W-1:0]     rrow_reg, rrow_next;
    logic [tmt_pkg::RCOL_W-1:0]     rcol_reg, rcol_next;
    logic [tmt_pkg::CELL_W-1:0]     cell_reg, cell_next;
    logic                           scroll_reg, scroll_next;
    logic                           mval_reg, mval_next;
    logic [tmt_pkg::OROW_W-1:0]     orow_reg, orow_next;
    logic [tmt_pkg::OCOL_W-1:0]     ocol_reg, ocol_next;
    logic [tmt_pkg::OLIN_W-1:0]     olin_reg, olin_next;
    logic [tmt_pkg::CELL_W-1:0]     ocell_reg, ocell_next;
    logic                           oscroll_reg, oscroll_next;

    logic                           s_accept;
    logic                           out_free;
    logic [7:0]                     attr;
    logic [tmt_pkg::CELL_W-1:0]     blank;
    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [tmt_pkg::CELL_W-1:0]     ram_wdata;
    logic                           ram_re;
    logic [AW-1:0]                  ram_raddr;
    logic [tmt_pkg::CELL_W-1:0]     ram_rdata;

    logic                           op_put, is_nl, is_cr, is_bs, is_glyph;
    logic                           col_last, row_last, col_zero;
    logic                           need_scroll, rd_ok;
    logic [31:0]                    rd_lin;
    logic [AW-1:0]                  cur_addr;
    logic [31:0]                    row_ext, col_ext, lin_ext;

    tmt_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .attr    (attr)
    );

    tmt_screen_ram #(.DEPTH(CELLS), .AW(AW)) u_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign blank    = {attr, tmt_pkg::CH_SPACE};
    assign out_free = !mval_reg || m_tready;
    assign s_tready = (state_reg == tmt_pkg::ST_IDLE) ||
                      ((state_reg == tmt_pkg::ST_DONE) && out_free);
    assign s_accept = s_tvalid && s_tready;

    assign op_put      = (op_reg == tmt_pkg::OP_PUT);
    assign is_nl       = (ch_reg == tmt_pkg::CH_NEWLINE);
    assign is_cr       = (ch_reg == tmt_pkg::CH_RETURN);
    assign is_bs       = (ch_reg == tmt_pkg::CH_BACKSPACE);
    assign is_glyph    = !is_nl && !is_cr && !is_bs;
    assign col_last    = (col_reg == LAST_COL);
    assign row_last    = (row_reg == LAST_ROW);
    assign col_zero    = (col_reg == '0);
    assign need_scroll = op_put && row_last && (is_nl || (is_glyph && col_last));
    assign rd_ok       = (32'(rrow_reg) < 32'(SCREEN_ROWS)) &&
                         (32'(rcol_reg) < 32'(SCREEN_COLUMNS));
    assign rd_lin      = 32'(rrow_reg) * 32'(SCREEN_COLUMNS) + 32'(rcol_reg);
    assign cur_addr    = base_reg + AW'(col_reg);

    assign row_ext = 32'(row_reg);
    assign col_ext = 32'(col_reg);
    assign lin_ext = 32'(cur_addr);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tmt_pkg::ST_INIT:
            begin
                if (cnt_reg == LAST_CELL)
                begin
                    state_next = tmt_pkg::ST_IDLE;
                end
            end
            tmt_pkg::ST_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = tmt_pkg::ST_EXEC;
                end
            end
            tmt_pkg::ST_EXEC:
            begin
                if (need_scroll)
                begin
                    state_next = tmt_pkg::ST_COPY;
                end
                else if (op_reg == tmt_pkg::OP_CLEAR)
                begin
                    state_next = tmt_pkg::ST_FILL;
                end
                else if ((op_reg == tmt_pkg::OP_READ) && rd_ok)
                begin
                    state_next = tmt_pkg::ST_RWAIT;
                end
                else
                begin
                    state_next = tmt_pkg::ST_DONE;
                end
            end
            tmt_pkg::ST_RWAIT:
            begin
                state_next = tmt_pkg::ST_DONE;
            end
            tmt_pkg::ST_COPY:
            begin
                if (cnt_reg == COPY_N)
                begin
                    state_next = tmt_pkg::ST_FILL;
                end
            end
            tmt_pkg::ST_FILL:
            begin
                if (cnt_reg == LAST_CELL)
                begin
                    state_next = tmt_pkg::ST_DONE;
                end
            end
            tmt_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = s_accept ? tmt_pkg::ST_EXEC : tmt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tmt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cnt_next     = cnt_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        base_next    = base_reg;
        op_next      = op_reg;
        ch_next      = ch_reg;
        rrow_next    = rrow_reg;
        rcol_next    = rcol_reg;
        cell_next    = cell_reg;
        scroll_next  = scroll_reg;
        mval_next    = mval_reg && !m_tready;
        orow_next    = orow_reg;
        ocol_next    = ocol_reg;
        olin_next    = olin_reg;
        ocell_next   = ocell_reg;
        oscroll_next = oscroll_reg;
        ram_we       = 1'b0;
        ram_waddr    = cnt_reg;
        ram_wdata    = blank;
        ram_re       = 1'b0;
        ram_raddr    = cnt_reg + COLS_A;

        if (s_accept)
        begin
            op_next   = s_tdata[1:0];
            ch_next   = s_tdata[9:2];
            rrow_next = s_tdata[14:10];
            rcol_next = s_tdata[21:15];
        end

        case (state_reg)
            tmt_pkg::ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_wdata = tmt_pkg::RESET_CELL;
                cnt_next  = (cnt_reg == LAST_CELL) ? '0 : cnt_reg + AW'(1);
            end
            tmt_pkg::ST_EXEC:
            begin
                cell_next   = '0;
                scroll_next = need_scroll;
                cnt_next    = '0;
                case (op_reg)
                    tmt_pkg::OP_PUT:
                    begin
                        if (is_nl)
                        begin
                            col_next = '0;
                            if (!row_last)
                            begin
                                row_next  = row_reg + RW'(1);
                                base_next = base_reg + COLS_A;
                            end
                        end
                        else if (is_cr)
                        begin
                            col_next = '0;
                        end
                        else if (is_bs)
                        begin
                            if (!col_zero)
                            begin
                                col_next  = col_reg - CW'(1);
                                ram_we    = 1'b1;
                                ram_waddr = cur_addr - AW'(1);
                                ram_wdata = blank;
                            end
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = cur_addr;
                            ram_wdata = {attr, ch_reg};
                            if (col_last)
                            begin
                                col_next = '0;
                                if (!row_last)
                                begin
                                    row_next  = row_reg + RW'(1);
                                    base_next = base_reg + COLS_A;
                                end
                            end
                            else
                            begin
                                col_next = col_reg + CW'(1);
                            end
                        end
                    end
                    tmt_pkg::OP_CLEAR:
                    begin
                        row_next  = '0;
                        col_next  = '0;
                        base_next = '0;
                    end
                    tmt_pkg::OP_READ:
                    begin
                        ram_re    = rd_ok;
                        ram_raddr = rd_lin[AW-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            tmt_pkg::ST_RWAIT:
            begin
                cell_next = ram_rdata;
            end
            tmt_pkg::ST_COPY:
            begin
                ram_re    = (cnt_reg != COPY_N);
                ram_we    = (cnt_reg != '0);
                ram_waddr = cnt_reg - AW'(1);
                ram_wdata = ram_rdata;
                if (cnt_reg != COPY_N)
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            tmt_pkg::ST_FILL:
            begin
                ram_we   = 1'b1;
                cnt_next = (cnt_reg == LAST_CELL) ? '0 : cnt_reg + AW'(1);
            end
            tmt_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    mval_next    = 1'b1;
                    orow_next    = row_ext[tmt_pkg::OROW_W-1:0];
                    ocol_next    = col_ext[tmt_pkg::OCOL_W-1:0];
                    olin_next    = lin_ext[tmt_pkg::OLIN_W-1:0];
                    ocell_next   = cell_reg;
                    oscroll_next = scroll_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tmt_pkg::ST_INIT;
            cnt_reg   <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            base_reg  <= '0;
            mval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            base_reg  <= base_next;
            mval_reg  <= mval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        ch_reg      <= ch_next;
        rrow_reg    <= rrow_next;
        rcol_reg    <= rcol_next;
        cell_reg    <= cell_next;
        scroll_reg  <= scroll_next;
        orow_reg    <= orow_next;
        ocol_reg    <= ocol_next;
        olin_reg    <= olin_next;
        ocell_reg   <= ocell_next;
        oscroll_reg <= oscroll_next;
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = {oscroll_reg, ocell_reg, olin_reg, ocol_reg, orow_reg};

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_reg) < 32'(SCREEN_COLUMNS))
        else $error("cursor column past line end");

    a_base_tracks_row: assert property (@(posedge clk) disable iff (!rst_n)
        32'(base_reg) == 32'(row_reg) * 32'(SCREEN_COLUMNS))
        else $error("row base out of step with cursor row");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tmt_pkg::ST_INIT || state_reg == tmt_pkg::ST_COPY ||
         state_reg == tmt_pkg::ST_FILL) |-> !s_tready)
        else $error("input taken during store sweep");

    a_scroll_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tmt_pkg::ST_COPY) |-> (row_reg == LAST_ROW))
        else $error("scroll with cursor off the last row");

endmodule
